@@ sv/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Boot sequence controller package
// Word types, boot state codes, error codes and register map constants that
// the controller's modules share.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // Boot state codes.
   localparam logic [2:0] ST_RECOVERY = 3'd0;
   localparam logic [2:0] ST_FLAG     = 3'd1;
   localparam logic [2:0] ST_APP      = 3'd2;
   localparam logic [2:0] ST_WAIT     = 3'd3;
   localparam logic [2:0] ST_PROG     = 3'd4;
   localparam logic [2:0] ST_VERIFY   = 3'd5;
   localparam logic [2:0] ST_JUMP     = 3'd6;
   localparam logic [2:0] ST_ERROR    = 3'd7;

   // Sticky error codes.
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_PROG   = 3'd1;
   localparam logic [2:0] ERR_CLEAR  = 3'd2;
   localparam logic [2:0] ERR_VERIFY = 3'd3;
   localparam logic [2:0] ERR_JUMP   = 3'd4;

   // Recovery status and programming status codes.
   localparam logic [1:0] REC_NO    = 2'd0;
   localparam logic [1:0] REC_YES   = 2'd1;
   localparam logic [1:0] PROG_DONE = 2'd1;
   localparam logic [1:0] PROG_FAIL = 2'd2;

   // Register map: one 32-bit register, index taken from address bit 2.
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam int unsigned CSR_DATA_W      = 32;
   localparam logic        CSR_IDX_TIMEOUT = 1'b0;
   localparam logic [31:0] TIMEOUT_RESET   = 32'd1000;
   localparam logic [31:0] WAIT_MAX        = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0] recovery_status;
      logic       update_flag_stored;
      logic       app_present;
      logic       app_check_ok;
      logic       update_request;
      logic [1:0] program_status;
      logic       clear_flag_ok;
   } req_word_type;

   typedef struct packed {
      logic [2:0] boot_state;
      logic [2:0] fault_code;
      logic       image_marked;
      logic       update_flag_seen;
      logic       jump_request;
      logic       clear_flag_request;
      logic       program_active;
   } rsp_word_type;

endpackage

@@ sv/bsc_csr.sv @@
// ----------------------------------------------------------------------------
// Boot sequence controller register block
// APB-style register file holding the recovery wait timeout.
// ----------------------------------------------------------------------------
module bsc_csr
   import bsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [31:0]           timeout
);

   logic [31:0] timeout_ff;
   logic [31:0] timeout_in;
   logic        hit_timeout;

   assign hit_timeout = (csr_paddr[2] == CSR_IDX_TIMEOUT);

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_timeout) begin
         timeout_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit_timeout ? timeout_ff : '0;
   assign timeout    = timeout_ff;

endmodule

@@ sv/bsc_step.sv @@
// ----------------------------------------------------------------------------
// Boot sequence controller step unit
// Holds the boot state, wait counter, error code and flags, and works out
// one result word per step from the current state and the status word.
// ----------------------------------------------------------------------------
module bsc_step
   import bsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_word_type item,
   input  logic [31:0]  timeout,
   output rsp_word_type result
);

   logic [2:0]  state_ff, state_in;
   logic [31:0] wait_ff, wait_in;
   logic [2:0]  error_ff, error_in;
   logic        flag_seen_ff, flag_seen_in;
   logic        valid_mark_ff, valid_mark_in;
   logic        jump_req, clear_req, prog_act;
   logic [31:0] wait_next;

   // Saturating increment, used only while in the recovery check.
   assign wait_next = (wait_ff != WAIT_MAX) ? wait_ff + 32'd1 : wait_ff;

   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      error_in      = error_ff;
      flag_seen_in  = flag_seen_ff;
      valid_mark_in = valid_mark_ff;
      jump_req      = 1'b0;
      clear_req     = 1'b0;
      prog_act      = 1'b0;
      case (state_ff)
         ST_RECOVERY: begin
            wait_in = wait_next;
            if (item.recovery_status == REC_NO && wait_next >= timeout) begin
               state_in = ST_FLAG;
            end else if (item.recovery_status == REC_YES) begin
               state_in = ST_PROG;
            end
         end
         ST_FLAG: begin
            flag_seen_in = item.update_flag_stored;
            state_in     = item.update_flag_stored ? ST_WAIT : ST_APP;
         end
         ST_APP: begin
            if (!item.app_present || !item.app_check_ok) begin
               state_in = ST_WAIT;
            end else begin
               valid_mark_in = 1'b1;
               state_in      = ST_JUMP;
            end
         end
         ST_PROG: begin
            prog_act = 1'b1;
            if (item.program_status == PROG_DONE) begin
               state_in = ST_VERIFY;
            end else if (item.program_status == PROG_FAIL) begin
               error_in = ERR_PROG;
               state_in = ST_WAIT;
            end
         end
         ST_VERIFY: begin
            if (item.app_check_ok) begin
               clear_req = 1'b1;
               if (!item.clear_flag_ok) begin
                  error_in = ERR_CLEAR;
               end
               valid_mark_in = 1'b1;
               state_in      = ST_JUMP;
            end else begin
               error_in = ERR_VERIFY;
               state_in = ST_WAIT;
            end
         end
         ST_JUMP: begin
            jump_req = 1'b1;
            error_in = ERR_JUMP;
            state_in = ST_WAIT;
         end
         default: begin
            // Wait update and error state behave the same.
            if (item.update_request) begin
               state_in = ST_PROG;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RECOVERY;
         wait_ff       <= '0;
         error_ff      <= ERR_NONE;
         flag_seen_ff  <= 1'b0;
         valid_mark_ff <= 1'b0;
      end else if (step_en) begin
         state_ff      <= state_in;
         wait_ff       <= wait_in;
         error_ff      <= error_in;
         flag_seen_ff  <= flag_seen_in;
         valid_mark_ff <= valid_mark_in;
      end
   end

   assign result.boot_state         = state_in;
   assign result.fault_code         = error_in;
   assign result.image_marked       = valid_mark_in;
   assign result.update_flag_seen   = flag_seen_in;
   assign result.jump_request       = jump_req;
   assign result.clear_flag_request = clear_req;
   assign result.program_active     = prog_act;

   // Once an error is recorded, only a reset clears it.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff != ERR_NONE |=> error_ff != ERR_NONE)
      else $error("error code cleared without reset");

   // The application mark never falls back.
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      valid_mark_ff |=> valid_mark_ff)
      else $error("application valid mark cleared");

   // The wait counter moves only on a step taken in the recovery check.
   a_wait_only_recovery: assert property (@(posedge clock) disable iff (reset)
      (step_en && state_ff != ST_RECOVERY) |=> $stable(wait_ff))
      else $error("wait counter moved outside the recovery check");

endmodule

@@ sv/boot_sequence_controller.sv @@
// ----------------------------------------------------------------------------
// Boot sequence controller
// Steps the boot state machine once per status word and reports the state,
// error code, flags and one-step requests for each step.
// ----------------------------------------------------------------------------
// Usage: each word on the req_ channel is one step tick carrying the status
// answers that the boot states query. The word is taken at a rising edge
// where req_valid is high and req_stall is low. Every word produces exactly
// one word on the rsp_ channel, taken where rsp_valid is high and rsp_stall
// is low.
// A word is registered in the input register and is then stepped into the result
// register, which drives rsp_valid; while the result register is full and
// stalled, the word waits in the input register.
// A new word can be taken every cycle, so sustained throughput is one word per
// cycle; the only thing that limits it is the receiver taking results.
// When the receiver stalls, the result register holds its word and the input
// register keeps the next one, so a word is still taken while a finished
// result waits; req_stall rises only once both registers are full and the
// result cannot move.
// Reset is synchronous and active high: it empties both registers, puts the
// machine in the recovery check with a zero wait counter, no error and both
// flags clear, and loads the wait timeout register with 1000 ticks.
// The timeout register sits at byte address 0 of the csr_ port and should be
// written only while no word is in flight.
// ----------------------------------------------------------------------------
module boot_sequence_controller
   import bsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Status word channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_recovery_status,
   input  logic                  req_update_flag_stored,
   input  logic                  req_app_present,
   input  logic                  req_app_check_ok,
   input  logic                  req_update_request,
   input  logic [1:0]            req_program_status,
   input  logic                  req_clear_flag_ok,
   // Result word channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_boot_state,
   output logic [2:0]            rsp_fault_code,
   output logic                  rsp_image_marked,
   output logic                  rsp_update_flag_seen,
   output logic                  rsp_jump_request,
   output logic                  rsp_clear_flag_request,
   output logic                  rsp_program_active,
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [31:0]  timeout;
   req_word_type req_word;
   req_word_type hold_ff, hold_in;
   logic         hold_valid_ff, hold_valid_in;
   rsp_word_type step_word;
   rsp_word_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         req_take;
   logic         advance;

   bsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeout     (timeout)
   );

   assign req_word.recovery_status    = req_recovery_status;
   assign req_word.update_flag_stored = req_update_flag_stored;
   assign req_word.app_present        = req_app_present;
   assign req_word.app_check_ok       = req_app_check_ok;
   assign req_word.update_request     = req_update_request;
   assign req_word.program_status     = req_program_status;
   assign req_word.clear_flag_ok      = req_clear_flag_ok;

   // The held word steps the machine whenever the result register is free
   // or is being emptied in this same cycle.
   assign advance   = hold_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = hold_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      hold_in       = req_take ? req_word : hold_ff;
      hold_valid_in = req_take || (hold_valid_ff && !advance);
      out_in        = advance ? step_word : out_ff;
      out_valid_in  = advance || (out_valid_ff && rsp_stall);
   end

   bsc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (hold_ff),
      .timeout (timeout),
      .result  (step_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_boot_state         = out_ff.boot_state;
   assign rsp_fault_code         = out_ff.fault_code;
   assign rsp_image_marked       = out_ff.image_marked;
   assign rsp_update_flag_seen   = out_ff.update_flag_seen;
   assign rsp_jump_request       = out_ff.jump_request;
   assign rsp_clear_flag_request = out_ff.clear_flag_request;
   assign rsp_program_active     = out_ff.program_active;

   // A jump step always lands in wait update.
   a_jump_to_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_jump_request) |-> rsp_boot_state == ST_WAIT)
      else $error("jump request without a move to wait update");

endmodule

@@ sim/boot_sequence_controller_tb.sv @@
// ----------------------------------------------------------------------------
// Boot sequence controller testbench
// Drives status words into the controller and checks every result word
// against a cycle-free model of the boot state machine. The run has two parts.
// The directed part walks the recovery check under three timeout settings,
// takes the exit into the flag check or programming, and then walks every
// branch of the update loop. The random part runs four phases of random words
// under different timeout settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module boot_sequence_controller_tb;
   import bsc_pkg::*;

   // Status codes that the package leaves unnamed.
   localparam logic [1:0] REC_UNSURE = 2'd2;
   localparam logic [1:0] REC_UNDEF  = 2'd3;
   localparam logic [1:0] PROG_BUSY  = 2'd0;
   localparam logic [1:0] PROG_UNDEF = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = {CSR_IDX_TIMEOUT, 2'b00};

   localparam int RANDOM_WORDS   = 1000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // Everything the boot machine remembers from one tick to the next,
   // together with the timeout register that steers the recovery check.
   typedef struct {
      logic [2:0]  state;
      logic [31:0] wait_count;
      logic [2:0]  error;
      logic        flag_seen;
      logic        valid_mark;
      logic [31:0] timeout;
   } boot_ctx_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid              = 1'b0;
   logic       req_stall;
   logic [1:0] req_recovery_status    = '0;
   logic       req_update_flag_stored = 1'b0;
   logic       req_app_present        = 1'b0;
   logic       req_app_check_ok       = 1'b0;
   logic       req_update_request     = 1'b0;
   logic [1:0] req_program_status     = '0;
   logic       req_clear_flag_ok      = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_boot_state;
   logic [2:0] rsp_fault_code;
   logic       rsp_image_marked;
   logic       rsp_update_flag_seen;
   logic       rsp_jump_request;
   logic       rsp_clear_flag_request;
   logic       rsp_program_active;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Words waiting to be driven, and result words predicted for accepted ones.
   req_word_type status_q[$];
   rsp_word_type expected_q[$];

   // The stimulus side steers with its own copy of the machine; the checking
   // side keeps a second copy that only advances on accepted words.
   boot_ctx_type plan_ctx;
   boot_ctx_type check_ctx;

   logic req_taken     = 1'b0;
   int   idle_cycles   = 0;
   int   fault_count   = 0;
   int   words_checked = 0;

   int req_gap_left   = 0;
   int req_calm_left  = 0;
   int stall_left     = 0;
   int free_left      = 0;
   int stall_calm_left = 0;

   boot_sequence_controller dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_recovery_status   (req_recovery_status),
      .req_update_flag_stored(req_update_flag_stored),
      .req_app_present       (req_app_present),
      .req_app_check_ok      (req_app_check_ok),
      .req_update_request    (req_update_request),
      .req_program_status    (req_program_status),
      .req_clear_flag_ok     (req_clear_flag_ok),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_boot_state        (rsp_boot_state),
      .rsp_fault_code        (rsp_fault_code),
      .rsp_image_marked      (rsp_image_marked),
      .rsp_update_flag_seen  (rsp_update_flag_seen),
      .rsp_jump_request      (rsp_jump_request),
      .rsp_clear_flag_request(rsp_clear_flag_request),
      .rsp_program_active    (rsp_program_active),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Boot machine model
   // ------------------------------------------------------------------------

   function automatic boot_ctx_type boot_ctx_reset();
      boot_ctx_type ctx;
      ctx.state      = ST_RECOVERY;
      ctx.wait_count = '0;
      ctx.error      = ERR_NONE;
      ctx.flag_seen  = 1'b0;
      ctx.valid_mark = 1'b0;
      ctx.timeout    = TIMEOUT_RESET;
      return ctx;
   endfunction

   // One tick: run the action of the current state on the status word, move
   // to the state that the outcome selects, and build the result word.
   function automatic rsp_word_type boot_step(inout boot_ctx_type ctx,
                                              input req_word_type w);
      rsp_word_type r;
      logic [2:0]   nxt;
      r   = '0;
      nxt = ctx.state;
      case (ctx.state)
         ST_RECOVERY: begin
            // The counter saturates and is only cleared by reset, so a long
            // stay followed by a smaller timeout exits at once.
            if (ctx.wait_count != WAIT_MAX) begin
               ctx.wait_count = ctx.wait_count + 32'd1;
            end
            if (w.recovery_status == REC_NO && ctx.wait_count >= ctx.timeout) begin
               nxt = ST_FLAG;
            end else if (w.recovery_status == REC_YES) begin
               nxt = ST_PROG;
            end
         end
         ST_FLAG: begin
            ctx.flag_seen = w.update_flag_stored;
            nxt = w.update_flag_stored ? ST_WAIT : ST_APP;
         end
         ST_APP: begin
            if (!w.app_present || !w.app_check_ok) begin
               nxt = ST_WAIT;
            end else begin
               ctx.valid_mark = 1'b1;
               nxt = ST_JUMP;
            end
         end
         ST_PROG: begin
            r.program_active = 1'b1;
            if (w.program_status == PROG_DONE) begin
               nxt = ST_VERIFY;
            end else if (w.program_status == PROG_FAIL) begin
               ctx.error = ERR_PROG;
               nxt = ST_WAIT;
            end
         end
         ST_VERIFY: begin
            if (w.app_check_ok) begin
               r.clear_flag_request = 1'b1;
               if (!w.clear_flag_ok) begin
                  ctx.error = ERR_CLEAR;
               end
               ctx.valid_mark = 1'b1;
               nxt = ST_JUMP;
            end else begin
               ctx.error = ERR_VERIFY;
               nxt = ST_WAIT;
            end
         end
         ST_JUMP: begin
            // Any tick spent here means control came back from the image.
            r.jump_request = 1'b1;
            ctx.error = ERR_JUMP;
            nxt = ST_WAIT;
         end
         default: begin
            // Wait update and the error state behave alike.
            if (w.update_request) begin
               nxt = ST_PROG;
            end
         end
      endcase
      ctx.state          = nxt;
      r.boot_state       = nxt;
      r.fault_code       = ctx.error;
      r.image_marked     = ctx.valid_mark;
      r.update_flag_seen = ctx.flag_seen;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.recovery_status    = 2'($urandom_range(0, 3));
      w.update_flag_stored = 1'($urandom_range(0, 1));
      w.app_present        = 1'($urandom_range(0, 1));
      w.app_check_ok       = 1'($urandom_range(0, 1));
      w.update_request     = 1'($urandom_range(0, 1));
      w.program_status     = 2'($urandom_range(0, 3));
      w.clear_flag_ok      = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic push_word(input req_word_type w);
      status_q.push_back(w);
      void'(boot_step(plan_ctx, w));
   endtask

   task automatic push_recovery(input logic [1:0] code);
      req_word_type w;
      w = random_word();
      w.recovery_status = code;
      push_word(w);
   endtask

   // One step of the update loop; the fields that no state reads stay random.
   task automatic walk(input logic upd, input logic [1:0] prog, input logic ok,
                       input logic clr);
      req_word_type w;
      w = random_word();
      w.update_request = upd;
      w.program_status = prog;
      w.app_check_ok   = ok;
      w.clear_flag_ok  = clr;
      push_word(w);
   endtask

   task automatic log_fault(input string msg);
      fault_count = fault_count + 1;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         log_fault($sformatf("result %0d, %s: expected %0h, got %0h",
                             words_checked, name, want, seen));
      end
   endtask

   // Returns once every queued word has been taken and answered and the
   // pipeline has been given time to empty.
   task automatic drain();
      while (status_q.size() != 0 || req_valid || expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the timeout register, reads it back, and hands the new value to
   // both model copies. Only called while nothing is in flight.
   task automatic set_timeout(input logic [31:0] value);
      logic [31:0] back;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TIMEOUT_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      back = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (back !== value) begin
         log_fault($sformatf("timeout readback: expected %0h, got %0h", value, back));
      end
      plan_ctx.timeout  = value;
      check_ctx.timeout = value;
   endtask

   // ------------------------------------------------------------------------
   // Status word driver: a word stays on the port until it is taken, and a
   // random gap may follow each one.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : status_driver
      req_word_type next_w;
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap_left > 0) begin
            req_gap_left = req_gap_left - 1;
            req_valid <= 1'b0;
         end else if (status_q.size() != 0) begin
            next_w = status_q.pop_front();
            req_recovery_status    <= next_w.recovery_status;
            req_update_flag_stored <= next_w.update_flag_stored;
            req_app_present        <= next_w.app_present;
            req_app_check_ok       <= next_w.app_check_ok;
            req_update_request     <= next_w.update_request;
            req_program_status     <= next_w.program_status;
            req_clear_flag_ok      <= next_w.clear_flag_ok;
            req_valid              <= 1'b1;
            // Calm stretches send words back to back for a while.
            if (req_calm_left > 0) begin
               req_gap_left  = 0;
               req_calm_left = req_calm_left - 1;
            end else begin
               req_gap_left = pick_gap();
               if ($urandom_range(0, 99) == 0) begin
                  req_calm_left = $urandom_range(20, 60);
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result stall: free runs of random length alternate with stall bursts.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : result_stall
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (free_left > 0) begin
            free_left = free_left - 1;
         end else begin
            free_left = $urandom_range(0, 15);
            if (stall_calm_left > 0) begin
               stall_left      = 0;
               stall_calm_left = stall_calm_left - 1;
            end else begin
               stall_left = pick_gap();
               if ($urandom_range(0, 49) == 0) begin
                  stall_calm_left = $urandom_range(5, 15);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predicts on every accepted status word and checks every
   // accepted result word against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      req_word_type seen_w;
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         check_ctx = boot_ctx_reset();
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen_w.recovery_status    = req_recovery_status;
            seen_w.update_flag_stored = req_update_flag_stored;
            seen_w.app_present        = req_app_present;
            seen_w.app_check_ok       = req_app_check_ok;
            seen_w.update_request     = req_update_request;
            seen_w.program_status     = req_program_status;
            seen_w.clear_flag_ok      = req_clear_flag_ok;
            expected_q.push_back(boot_step(check_ctx, seen_w));
         end
         if (rsp_valid && !rsp_stall) begin
            got.boot_state         = rsp_boot_state;
            got.fault_code         = rsp_fault_code;
            got.image_marked       = rsp_image_marked;
            got.update_flag_seen   = rsp_update_flag_seen;
            got.jump_request       = rsp_jump_request;
            got.clear_flag_request = rsp_clear_flag_request;
            got.program_active     = rsp_program_active;
            if (expected_q.size() == 0) begin
               log_fault($sformatf("result %0d arrived with nothing expected", words_checked));
            end else begin
               want = expected_q.pop_front();
               check_field("boot_state", want.boot_state, got.boot_state);
               check_field("fault_code", want.fault_code, got.fault_code);
               check_field("image_marked", want.image_marked, got.image_marked);
               check_field("update_flag_seen", want.update_flag_seen, got.update_flag_seen);
               check_field("jump_request", want.jump_request, got.jump_request);
               check_field("clear_flag_request", want.clear_flag_request,
                           got.clear_flag_request);
               check_field("program_active", want.program_active, got.program_active);
            end
            words_checked = words_checked + 1;
         end
         // Watchdog: any handshake or register access counts as progress.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      req_word_type w;
      plan_ctx = boot_ctx_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Recovery check under the reset timeout of 1000 ticks: undecided,
      // the undefined code that counts as undecided, and a plain no all hold.
      push_recovery(REC_UNSURE);
      push_recovery(REC_UNDEF);
      push_recovery(REC_NO);
      drain();

      // The largest timeout lies far beyond the wait count here, so a no still holds.
      set_timeout(WAIT_MAX);
      push_recovery(REC_NO);
      push_recovery(REC_UNSURE);
      drain();

      // A timeout of zero or one: the counter is already past it, so the
      // first no leaves for the flag check. Now and then the run takes the
      // recovery path straight into programming instead.
      set_timeout($urandom_range(0, 1));
      push_recovery(REC_UNDEF);
      push_recovery(($urandom_range(0, 3) == 0) ? REC_YES : REC_NO);

      // Whatever path the exit took, fail forward until the machine sits in
      // wait update. Along the way the flag and application checks see
      // random answers, mostly with the update flag clear.
      while (plan_ctx.state != ST_WAIT) begin
         w = random_word();
         w.update_flag_stored = ($urandom_range(0, 3) == 0);
         w.update_request     = 1'b0;
         w.program_status     = PROG_FAIL;
         push_word(w);
      end

      // Every branch of the update loop, in order: hold in wait update,
      // programming busy and the undefined code, programming failure,
      // verify failure, verify with a failed flag clear, the jump that
      // returns, and a clean verify.
      walk(1'b0, PROG_BUSY, 1'b0, 1'b0);
      walk(1'b1, PROG_BUSY, 1'b0, 1'b0);
      walk(1'b0, PROG_BUSY, 1'b1, 1'b1);
      walk(1'b0, PROG_UNDEF, 1'b1, 1'b1);
      walk(1'b0, PROG_FAIL, 1'b0, 1'b0);
      walk(1'b1, PROG_BUSY, 1'b0, 1'b0);
      walk(1'b0, PROG_DONE, 1'b0, 1'b0);
      walk(1'b0, PROG_BUSY, 1'b0, 1'b1);
      walk(1'b1, PROG_BUSY, 1'b0, 1'b0);
      walk(1'b0, PROG_DONE, 1'b0, 1'b0);
      walk(1'b0, PROG_BUSY, 1'b1, 1'b0);
      walk(1'b0, PROG_BUSY, 1'b0, 1'b0);
      walk(1'b1, PROG_BUSY, 1'b0, 1'b0);
      walk(1'b0, PROG_DONE, 1'b0, 1'b0);
      walk(1'b0, PROG_BUSY, 1'b1, 1'b1);
      walk(1'b1, PROG_BUSY, 1'b1, 1'b1);

      // Random words in four phases. Fully random answers already travel
      // the whole update loop, so no shaping is needed; each phase moves the
      // timeout to another setting, the extremes among them.
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: set_timeout('0);
            1: set_timeout(TIMEOUT_RESET);
            2: set_timeout(WAIT_MAX);
            default: set_timeout($urandom());
         endcase
         repeat (RANDOM_WORDS / 4) push_word(random_word());
      end

      drain();
      if (fault_count == 0 && expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ boot_sequence_controller.f @@
sv/bsc_pkg.sv
sv/bsc_csr.sv
sv/bsc_step.sv
sv/boot_sequence_controller.sv
sim/boot_sequence_controller_tb.sv
